@@ rtl/bdcc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdcc_pkg: shared types and codes for the button debounce / click classifier
// Holds the phase encoding, event codes, register indexes and result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned InW    = 40;  // 33 payload bits padded to bytes
  localparam int unsigned OutW   = 16;  // 11 payload bits padded to bytes

  // configuration register indexes
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_MULTICLICK = 1'b1;

  typedef enum logic [4:0] {
    PH_RELEASED   = 5'b00001,
    PH_DEB_ACTIVE = 5'b00010,
    PH_ACTIVE     = 5'b00100,
    PH_DEB_REL    = 5'b01000,
    PH_LONG       = 5'b10000
  } bdcc_phase_t;

  typedef enum logic [KindW-1:0] {
    EV_RELEASED = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_LONG     = 2'd2,
    EV_MULTI    = 2'd3
  } bdcc_kind_t;

  typedef struct packed {
    logic              valid;
    bdcc_kind_t        kind;
    logic [CountW-1:0] count;
    logic              active;
  } bdcc_result_t;

endpackage

`default_nettype wire

@@ rtl/bdcc_core.sv @@
// ----------------------------------------------------------------------------
// bdcc_core: phase machine and click state
// Applies one sample per step and forms at most one event combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_core
  import bdcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [TimeW-1:0]  now_ms,
  input  wire logic              pin_level,
  input  wire logic [TimeW-1:0]  debounce_ms,
  input  wire logic [TimeW-1:0]  multiclick_delay_ms,
  output bdcc_result_t           res
);

  bdcc_phase_t       phase, phase_next;
  logic              last_level, last_level_next;
  logic [TimeW-1:0]  debounce_start, debounce_start_next;
  logic [TimeW-1:0]  click_start, click_start_next;
  logic [CountW-1:0] press_count, press_count_next;

  logic             in_deb, edge_seen, press_edge, release_edge;
  logic [TimeW-1:0] since_deb, since_click;
  logic             deb_done, click_over;

  assign in_deb       = (phase == PH_DEB_ACTIVE) || (phase == PH_DEB_REL);
  assign edge_seen    = !in_deb && (pin_level != last_level);
  assign press_edge   = edge_seen && !pin_level;
  assign release_edge = edge_seen && pin_level;
  // modulo 2^32 elapsed times
  assign since_deb    = now_ms - debounce_start;
  assign since_click  = now_ms - click_start;
  assign deb_done     = since_deb >= debounce_ms;
  assign click_over   = since_click > multiclick_delay_ms;

  always_comb begin
    phase_next          = phase;
    last_level_next     = edge_seen ? pin_level : last_level;
    debounce_start_next = debounce_start;
    click_start_next    = click_start;
    press_count_next    = press_count;
    res                 = '{valid: 1'b0, kind: EV_RELEASED, count: '0, active: 1'b0};
    unique case (phase)
      PH_RELEASED: begin
        if (press_count != '0 && click_over) begin
          res              = '{valid: 1'b1, kind: EV_MULTI, count: press_count, active: 1'b0};
          press_count_next = '0;
        end
        if (press_edge) begin
          phase_next          = PH_DEB_ACTIVE;
          debounce_start_next = now_ms;
        end
      end
      PH_DEB_ACTIVE: begin
        if (deb_done) begin
          phase_next       = PH_ACTIVE;
          click_start_next = now_ms;
          press_count_next = press_count + 1'b1;
          res = '{valid: 1'b1, kind: EV_PRESSED, count: press_count + 1'b1, active: 1'b1};
        end
      end
      PH_ACTIVE: begin
        // long hold wins over a release edge in the same sample
        if (click_over) begin
          phase_next       = PH_LONG;
          press_count_next = '0;
          res = '{valid: 1'b1, kind: EV_LONG, count: '0, active: 1'b1};
        end else if (release_edge) begin
          phase_next          = PH_DEB_REL;
          debounce_start_next = now_ms;
        end
      end
      PH_DEB_REL: begin
        if (deb_done) begin
          phase_next = PH_RELEASED;
          res = '{valid: 1'b1, kind: EV_RELEASED, count: '0, active: 1'b0};
        end
      end
      PH_LONG: begin
        if (release_edge) begin
          phase_next          = PH_DEB_REL;
          debounce_start_next = now_ms;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RELEASED;
      last_level     <= 1'b0;
      debounce_start <= '1;
      click_start    <= '1;
      press_count    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      last_level     <= last_level_next;
      debounce_start <= debounce_start_next;
      click_start    <= click_start_next;
      press_count    <= press_count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_debounce_click_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_unit: debounced button event classifier
// Input register, phase machine and event output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample per request: a millisecond timestamp and the raw
//   pin level (0 = active). m_* carries events: released, pressed (with the
//   8-bit click count), long hold, or multiclick summary (with the count).
//   Samples that cause no event produce nothing on m_*.
//   cfg_we/cfg_addr/cfg_data write debounce_ms (index 0) and
//   multiclick_delay_ms (index 1); write only while the block is idle.
// Timing:
//   One sample per cycle sustained while m_tready is high. A sample sits in
//   the input register, is applied to the phase machine, and its event is
//   registered before it shows on m_*. The whole state update is one short
//   step (two 32-bit subtract/compares), so each stage holds one sample.
// Reset (rst, synchronous): phase released, last level 0, timestamps all
//   ones, count 0, registers 0, both stages empty.
// Stall: a held event blocks the phase machine; the input register, if empty,
//   still takes one more sample, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_classifier_unit
  import bdcc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output      logic            s_tready,
  input  wire logic [InW-1:0]  s_tdata,   // [31:0] now_ms, [32] pin_level
  output      logic            m_tvalid,
  input  wire logic            m_tready,
  output      logic [OutW-1:0] m_tdata,   // [1:0] event_kind, [9:2] click_count,
                                          // [10] active_flag
  input  wire logic            cfg_we,
  input  wire logic            cfg_addr,
  input  wire logic [TimeW-1:0] cfg_data
);

  logic [TimeW-1:0] debounce_ms, multiclick_delay_ms;
  logic             in_vld;
  logic [TimeW-1:0] in_now;
  logic             in_pin;
  logic             out_vld;
  bdcc_kind_t       out_kind;
  logic [CountW-1:0] out_count;
  logic             out_active;
  logic             step;
  bdcc_result_t     res;

  assign step     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms         <= '0;
      multiclick_delay_ms <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   debounce_ms         <= cfg_data;
        REG_MULTICLICK: multiclick_delay_ms <= cfg_data;
        default:        debounce_ms         <= debounce_ms;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now <= s_tdata[TimeW-1:0];
      in_pin <= s_tdata[TimeW];
    end
  end

  bdcc_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .now_ms              (in_now),
    .pin_level           (in_pin),
    .debounce_ms         (debounce_ms),
    .multiclick_delay_ms (multiclick_delay_ms),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      out_vld <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind   <= res.kind;
      out_count  <= res.count;
      out_active <= res.active;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(OutW - KindW - CountW - 1){1'b0}}, out_active, out_count, out_kind};

endmodule

`default_nettype wire

@@ rtl/bdcc_checker.sv @@
// ----------------------------------------------------------------------------
// bdcc_checker: port-level checks for the click classifier
// Watches the event channel; ties released, long and multi kinds to fields.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_checker
  import bdcc_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            m_tvalid,
  input wire logic            m_tready,
  input wire logic [OutW-1:0] m_tdata
);

  logic [KindW-1:0]  kind;
  logic [CountW-1:0] count;
  logic              active;

  assign kind   = m_tdata[KindW-1:0];
  assign count  = m_tdata[KindW+CountW-1:KindW];
  assign active = m_tdata[KindW+CountW];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("event present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled event changed");

  a_released_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == EV_RELEASED |-> count == '0 && !active)
    else $error("released event with count or active set");

  a_long_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == EV_LONG |-> count == '0 && active)
    else $error("long hold event with bad fields");

  a_multi_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == EV_MULTI |-> count != '0 && !active)
    else $error("multiclick event with zero count or active set");

endmodule

bind button_debounce_click_classifier_unit bdcc_checker u_bdcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
